/* rtl/edge_lockout_key_debouncer_assert.svh */
// Assertion helpers shared by the debouncer RTL.
`ifndef EDGE_LOCKOUT_KEY_DEBOUNCER_ASSERT_SVH
`define EDGE_LOCKOUT_KEY_DEBOUNCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ELD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("debouncer assertion failed");

// Next-cycle implication, checked outside reset.
`define ELD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("debouncer assertion failed");

`endif

/* rtl/eld_pkg.sv */
`default_nettype none

package eld_pkg;

    // Field widths fixed by the item format
    localparam int KEY_W             = 5;
    localparam int TICK_W            = 8;
    localparam int TDATA_W           = 8;
    localparam int TUSER_W           = 2;
    localparam int CFG_INDEX_W       = 4;
    localparam int CFG_DATA_W        = 8;
    localparam int DEFAULT_KEY_COUNT = 5;
    localparam int RESULT_DEPTH      = 2;

    localparam logic [TICK_W-1:0] TICK_MAX              = '1;
    localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RESET  = 8'd5;
    localparam logic [KEY_W-1:0]  KEY_ENABLE_RESET      = 5'd31;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_ENABLE     = 4'd1;

    // What one key lane reports for the item it just took
    typedef struct packed {
        logic pressed;
        logic changed;
        logic too_short;
    } lane_status_t;

    typedef struct packed {
        logic             too_short;
        logic             state_changed;
        logic [KEY_W-1:0] key_state;
    } result_t;

endpackage

`default_nettype wire

/* rtl/edge_lockout_key_debouncer.sv */
// A result is buffered on s_ acceptance and offered on m_ in arrival order.
// Throughput: one item per cycle while s_tready is high; lanes update together.
// A two-entry result buffer keeps s_tready high while one result waits on m_.
// Reset (aresetn low, synchronous) clears key state, lockouts and counts,
// sets the previous levels to released and loads the register defaults.
`default_nettype none

module edge_lockout_key_debouncer
    import eld_pkg::*;
#(
    parameter int KEY_COUNT = DEFAULT_KEY_COUNT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [TDATA_W-1:0]     s_tdata,   // pin_levels[4:0], zero fill
    input  wire logic [TUSER_W-1:0]     s_tuser,   // tick, resync
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_W-1:0]          m_tdata,   // key_state[4:0], zero fill
    output logic [TUSER_W-1:0]          m_tuser,   // state_changed, too_short
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // keys past the pin field are never seen
    localparam int LANE_COUNT = (KEY_COUNT < KEY_W) ? KEY_COUNT : KEY_W;

    logic [TICK_W-1:0] debounce_ticks_reg;
    logic [KEY_W-1:0]  key_enable_reg;
    logic              accept;
    lane_status_t      lane_status [LANE_COUNT];

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg <= DEBOUNCE_TICKS_RESET;
            key_enable_reg     <= KEY_ENABLE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[TICK_W-1:0];
                REG_KEY_ENABLE:     key_enable_reg     <= cfg_data[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
        eld_lane u_lane (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .accept         (accept),
            .pin            (s_tdata[i]),
            .tick           (s_tuser[0]),
            .resync         (s_tuser[1]),
            .enable         (key_enable_reg[i]),
            .debounce_ticks (debounce_ticks_reg),
            .status         (lane_status[i])
        );
    end

    eld_merge #(
        .LANE_COUNT (LANE_COUNT)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (accept),
        .lane_status (lane_status),
        .in_ready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

/* rtl/eld_lane.sv */
`default_nettype none

module eld_lane
    import eld_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              pin,
    input  wire logic              tick,
    input  wire logic              resync,
    input  wire logic              enable,
    input  wire logic [TICK_W-1:0] debounce_ticks,
    output lane_status_t           status
);

    logic              pressed_reg, pressed_next;
    logic              locked_reg, locked_next;
    logic              prev_reg;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;

    logic              pressed_now;
    logic [TICK_W-1:0] count;
    logic              released;
    logic              edge_hit;
    logic              err;
    logic              trig;

    always_comb begin
        pressed_now = ~pin;
        count       = (locked_reg && tick && (elapsed_reg != TICK_MAX)) ?
                      elapsed_reg + TICK_W'(1) : elapsed_reg;
        released    = locked_reg && (count > debounce_ticks);
        edge_hit    = (pin ^ prev_reg) && enable && !locked_reg;
        err         = (pressed_reg ^ pressed_now) && released;
        trig        = edge_hit || (err && enable);

        if (resync) begin
            pressed_next     = pressed_now;
            locked_next      = 1'b0;
            elapsed_next     = '0;
            status.changed   = pressed_now ^ pressed_reg;
            status.too_short = 1'b0;
        end else begin
            pressed_next     = pressed_reg ^ trig;
            locked_next      = (locked_reg && !released) || trig;
            elapsed_next     = trig ? '0 : count;
            status.changed   = trig;
            status.too_short = err;
        end
        status.pressed = pressed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= 1'b0;
            locked_reg  <= 1'b0;
            prev_reg    <= 1'b1;
            elapsed_reg <= '0;
        end else if (accept) begin
            pressed_reg <= pressed_next;
            locked_reg  <= locked_next;
            prev_reg    <= pin;
            elapsed_reg <= elapsed_next;
        end
    end

`include "edge_lockout_key_debouncer_assert.svh"

    `ELD_ASSERT_NEXT(a_resync_clears, aclk, aresetn, accept && resync,
        !locked_reg && (elapsed_reg == '0))
    `ELD_ASSERT_NEXT(a_toggle_locks, aclk, aresetn, accept && !resync && trig,
        locked_reg && (elapsed_reg == '0))
    `ELD_ASSERT_NOW(a_unlocked_no_release, aclk, aresetn, !locked_reg, !released)

endmodule

`default_nettype wire

/* rtl/eld_merge.sv */
`default_nettype none

module eld_merge
    import eld_pkg::*;
#(
    parameter int LANE_COUNT = DEFAULT_KEY_COUNT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire lane_status_t lane_status [LANE_COUNT],
    output logic              in_ready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // key_state[4:0], zero fill
    output logic [TUSER_W-1:0] m_tuser    // state_changed, too_short
);

    localparam int PTR_W = $clog2(RESULT_DEPTH);
    localparam int CNT_W = $clog2(RESULT_DEPTH + 1);

    result_t            merged;
    result_t            buf_reg [RESULT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    always_comb begin
        merged = '0;
        for (int i = 0; i < LANE_COUNT; i++) begin
            merged.key_state[i]  = lane_status[i].pressed;
            merged.state_changed = merged.state_changed | lane_status[i].changed;
            merged.too_short     = merged.too_short | lane_status[i].too_short;
        end
    end

    assign in_ready = (count_reg != CNT_W'(RESULT_DEPTH));
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= merged;
        end
    end

    assign m_tdata = TDATA_W'(buf_reg[rd_ptr_reg].key_state);
    assign m_tuser = {buf_reg[rd_ptr_reg].too_short, buf_reg[rd_ptr_reg].state_changed};

`include "edge_lockout_key_debouncer_assert.svh"

    `ELD_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + CNT_W'(1))
    `ELD_ASSERT_NEXT(a_pop_shrinks, aclk, aresetn, pop && !push,
        count_reg == $past(count_reg) - CNT_W'(1))
    `ELD_ASSERT_NOW(a_no_overflow, aclk, aresetn, push, count_reg < CNT_W'(RESULT_DEPTH))

endmodule

`default_nettype wire
